/* src/ppt_pkg.sv */
// Shared types, widths and helpers for the parented point transform.
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int POS_W    = 32;  // Q16.16 position width
  localparam int ELEM_W   = 16;  // Q4.12 basis element width
  localparam int NAX      = 3;   // number of axes
  localparam int SQR_W    = 32;  // squared column length, Q8.24
  localparam int RAD_W    = 40;  // radicand of the length root
  localparam int ROOT_W   = 20;  // column length, unsigned Q4.16
  localparam int SQ_STEPS = 20;  // one root bit per stage
  localparam int MAG_W    = 48;  // magnitude of a projection
  localparam int NUM_W    = 54;  // rounding numerator
  localparam int DVS_W    = 21;  // divisor, twice the length
  localparam int Q_W      = 34;  // kept quotient bits, more saturate
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd2;

  localparam logic signed [35:0] POS_MAX = 36'sd2147483647;
  localparam logic signed [35:0] POS_MIN = -36'sd2147483648;

  typedef struct packed {
    logic signed [POS_W-1:0] local_x;
    logic signed [POS_W-1:0] local_y;
    logic signed [POS_W-1:0] local_z;
    logic                    has_parent;
    logic [3*ELEM_W-1:0]     basis_row0;
    logic [3*ELEM_W-1:0]     basis_row1;
    logic [3*ELEM_W-1:0]     basis_row2;
    logic signed [POS_W-1:0] parent_tx;
    logic signed [POS_W-1:0] parent_ty;
    logic signed [POS_W-1:0] parent_tz;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] world_x;
    logic signed [POS_W-1:0] world_y;
    logic signed [POS_W-1:0] world_z;
    logic                    degenerate_axis;
  } out_t;

  // Per-item data that rides alongside the length root.
  typedef struct packed {
    logic [NAX-1:0][POS_W-1:0] t;
    logic [NAX-1:0]            zero;
    logic [NAX-1:0]            neg;
    logic [NAX-1:0][MAG_W-1:0] mag;
    logic                      degen;
  } sq_side_t;

  // Per-item data that rides alongside the divider.
  typedef struct packed {
    logic [NAX-1:0][POS_W-1:0] t;
    logic [NAX-1:0]            zero;
    logic [NAX-1:0]            neg;
    logic                      degen;
  } dv_side_t;

  typedef struct packed {
    logic [NAX-1:0][SQR_W-1:0] s;
    sq_side_t                  side;
  } fr_out_t;

  typedef struct packed {
    logic [NAX-1:0][ROOT_W-1:0] len;
    sq_side_t                   side;
  } sq_out_t;

  typedef struct packed {
    logic [NAX-1:0][Q_W-1:0] q;
    dv_side_t                side;
  } dv_out_t;

  // Saturate a widened sum to the signed 32-bit range.
  function automatic logic [POS_W-1:0] sat32(input logic signed [35:0] v);
    if (v > POS_MAX) begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end else if (v < POS_MIN) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end
    return v[POS_W-1:0];
  endfunction

endpackage

/* src/ppt_front.sv */
// Front end: offset add, products and squares, column sums.
`timescale 1ns / 1ps
module ppt_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [ppt_pkg::NAX-1:0][ppt_pkg::POS_W-1:0] offset_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  ppt_pkg::in_t                              in_data_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output ppt_pkg::fr_out_t                          out_data_o
);
  import ppt_pkg::*;

  logic [2:0] v_q;
  logic [2:0] rdy;

  logic [NAX-1:0][POS_W-1:0]             p1_d, p1_q, t1_d, t1_q;
  logic [NAX-1:0][NAX-1:0][ELEM_W-1:0]   b1_d, b1_q;
  logic                                  hp1_q;
  logic [NAX-1:0][NAX-1:0][2*ELEM_W+15:0] prod2_d, prod2_q;
  logic [NAX-1:0][NAX-1:0][SQR_W-1:0]    sq2_d, sq2_q;
  logic [NAX-1:0][POS_W-1:0]             p2_q, t2_q;
  logic                                  hp2_q;
  fr_out_t                               fr_d, fr_q;

  // Each stage moves when it is empty or the next one moves.
  assign rdy[2] = !v_q[2] || !out_stall_i;
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: offset the point and unpack the basis.
  always_comb begin
    logic [NAX-1:0][POS_W-1:0] loc;
    logic [NAX-1:0][3*ELEM_W-1:0] rows;
    logic signed [POS_W:0] sm;
    loc  = {in_data_i.local_z, in_data_i.local_y, in_data_i.local_x};
    rows = {in_data_i.basis_row2, in_data_i.basis_row1, in_data_i.basis_row0};
    t1_d = {in_data_i.parent_tz, in_data_i.parent_ty, in_data_i.parent_tx};
    for (int i = 0; i < NAX; i++) begin
      sm = $signed({loc[i][POS_W-1], loc[i]}) + $signed({offset_i[i][POS_W-1], offset_i[i]});
      p1_d[i] = sat32(36'(sm));
      for (int j = 0; j < NAX; j++) begin
        b1_d[i][j] = rows[i][ELEM_W*j +: ELEM_W];
      end
    end
  end

  // Stage 2: all nine products and squares side by side.
  always_comb begin
    logic signed [2*ELEM_W+15:0] pr;
    logic signed [SQR_W-1:0] sq;
    for (int i = 0; i < NAX; i++) begin
      for (int j = 0; j < NAX; j++) begin
        pr = $signed(p1_q[i]) * $signed(b1_q[i][j]);
        sq = $signed(b1_q[i][j]) * $signed(b1_q[i][j]);
        prod2_d[i][j] = pr;
        sq2_d[i][j]   = sq;
      end
    end
  end

  // Stage 3: column sums, sign and magnitude of each projection.
  always_comb begin
    logic signed [MAG_W+1:0] ds;
    logic [SQR_W-1:0] ss;
    fr_d = '0;
    fr_d.side.degen = 1'b0;
    for (int j = 0; j < NAX; j++) begin
      ds = 50'($signed(prod2_q[0][j])) + 50'($signed(prod2_q[1][j]))
         + 50'($signed(prod2_q[2][j]));
      ss = sq2_q[0][j] + sq2_q[1][j] + sq2_q[2][j];
      fr_d.s[j]         = ss;
      fr_d.side.neg[j]  = ds[MAG_W+1];
      fr_d.side.mag[j]  = ds[MAG_W+1] ? MAG_W'(-ds) : ds[MAG_W-1:0];
      // Without a parent the point passes through as the translation.
      fr_d.side.zero[j] = !hp2_q || (ss == '0);
      fr_d.side.t[j]    = hp2_q ? t2_q[j] : p2_q[j];
      if (hp2_q && (ss == '0)) fr_d.side.degen = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p1_q  <= p1_d;
      b1_q  <= b1_d;
      t1_q  <= t1_d;
      hp1_q <= in_data_i.has_parent;
    end
    if (rdy[1]) begin
      prod2_q <= prod2_d;
      sq2_q   <= sq2_d;
      p2_q    <= p1_q;
      t2_q    <= t1_q;
      hp2_q   <= hp1_q;
    end
    if (rdy[2]) fr_q <= fr_d;
  end

  assign out_valid_o = v_q[2];
  assign out_data_o  = fr_q;

endmodule

/* src/ppt_sqrt.sv */
// Pipelined integer square root of the three column lengths, one bit per stage.
`timescale 1ns / 1ps
module ppt_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppt_pkg::fr_out_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ppt_pkg::sq_out_t out_data_o
);
  import ppt_pkg::*;

  typedef struct packed {
    logic [NAX-1:0][RAD_W-1:0]  x;
    logic [NAX-1:0][ROOT_W+1:0] rem;
    logic [NAX-1:0][ROOT_W-1:0] root;
    sq_side_t                   side;
  } sq_stage_t;

  sq_stage_t st_d [SQ_STEPS];
  sq_stage_t st_q [SQ_STEPS];
  logic [SQ_STEPS-1:0] v_q;
  logic [SQ_STEPS-1:0] rdy;

  // Ready chain from the output back to the input.
  always_comb begin
    rdy[SQ_STEPS-1] = !v_q[SQ_STEPS-1] || !out_stall_i;
    for (int k = SQ_STEPS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        if (rdy[k]) v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
      end
    end
  end

  // One restoring root step per stage: bring down two radicand bits.
  always_comb begin
    sq_stage_t src;
    logic [ROOT_W+3:0] rw, tr;
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        src.side = in_data_i.side;
        for (int j = 0; j < NAX; j++) begin
          src.x[j]    = {in_data_i.s[j], 8'h00};
          src.rem[j]  = '0;
          src.root[j] = '0;
        end
      end else begin
        src = st_q[k-1];
      end
      st_d[k].side = src.side;
      for (int j = 0; j < NAX; j++) begin
        rw = {src.rem[j], src.x[j][RAD_W-1 -: 2]};
        tr = {2'b00, src.root[j], 2'b01};
        st_d[k].x[j] = {src.x[j][RAD_W-3:0], 2'b00};
        if (rw >= tr) begin
          st_d[k].rem[j]  = (ROOT_W+2)'(rw - tr);
          st_d[k].root[j] = {src.root[j][ROOT_W-2:0], 1'b1};
        end else begin
          st_d[k].rem[j]  = rw[ROOT_W+1:0];
          st_d[k].root[j] = {src.root[j][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  assign out_valid_o = v_q[SQ_STEPS-1];
  always_comb begin
    out_data_o.side = st_q[SQ_STEPS-1].side;
    for (int j = 0; j < NAX; j++) begin
      out_data_o.len[j] = st_q[SQ_STEPS-1].root[j];
    end
  end

endmodule

/* src/ppt_div.sv */
// Pipelined rounding divider of projection by length, one quotient bit per stage.
`timescale 1ns / 1ps
module ppt_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppt_pkg::sq_out_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ppt_pkg::dv_out_t out_data_o
);
  import ppt_pkg::*;

  localparam int DV_STG = Q_W + 1;  // setup stage plus one per quotient bit

  typedef struct packed {
    logic [NAX-1:0][Q_W-1:0]   n;
    logic [NAX-1:0][DVS_W-1:0] rem;
    logic [NAX-1:0][DVS_W-1:0] dv;
    logic [NAX-1:0][Q_W-1:0]   q;
    logic [NAX-1:0]            ovf;
    dv_side_t                  side;
  } dv_stage_t;

  dv_stage_t st_d [DV_STG];
  dv_stage_t st_q [DV_STG];
  logic [DV_STG-1:0] v_q;
  logic [DV_STG-1:0] rdy;

  always_comb begin
    rdy[DV_STG-1] = !v_q[DV_STG-1] || !out_stall_i;
    for (int k = DV_STG - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DV_STG; k++) begin
        if (rdy[k]) v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
      end
    end
  end

  // Setup forms 32*|D| + L over 2*L; a high part not below the divisor
  // means the quotient is far beyond the output range.
  // Later stages do one restoring division step each.
  always_comb begin
    logic [NUM_W-1:0] num;
    logic [DVS_W:0]   rw;
    for (int k = 0; k < DV_STG; k++) begin
      if (k == 0) begin
        st_d[0].side.t     = in_data_i.side.t;
        st_d[0].side.zero  = in_data_i.side.zero;
        st_d[0].side.neg   = in_data_i.side.neg;
        st_d[0].side.degen = in_data_i.side.degen;
        for (int j = 0; j < NAX; j++) begin
          num = {1'b0, in_data_i.side.mag[j], 5'b00000} + NUM_W'(in_data_i.len[j]);
          st_d[0].dv[j]  = {in_data_i.len[j], 1'b0};
          st_d[0].rem[j] = {1'b0, num[NUM_W-1:Q_W]};
          st_d[0].ovf[j] = ({1'b0, num[NUM_W-1:Q_W]} >= {in_data_i.len[j], 1'b0});
          st_d[0].n[j]   = num[Q_W-1:0];
          st_d[0].q[j]   = '0;
        end
      end else begin
        st_d[k] = st_q[k-1];
        for (int j = 0; j < NAX; j++) begin
          rw = {st_q[k-1].rem[j], st_q[k-1].n[j][Q_W-1]};
          st_d[k].n[j] = {st_q[k-1].n[j][Q_W-2:0], 1'b0};
          if (rw >= {1'b0, st_q[k-1].dv[j]}) begin
            st_d[k].rem[j] = DVS_W'(rw - {1'b0, st_q[k-1].dv[j]});
            st_d[k].q[j]   = {st_q[k-1].q[j][Q_W-2:0], 1'b1};
          end else begin
            st_d[k].rem[j] = rw[DVS_W-1:0];
            st_d[k].q[j]   = {st_q[k-1].q[j][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DV_STG; k++) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  assign out_valid_o = v_q[DV_STG-1];
  always_comb begin
    out_data_o.side = st_q[DV_STG-1].side;
    for (int j = 0; j < NAX; j++) begin
      out_data_o.q[j] = st_q[DV_STG-1].ovf[j] ? {Q_W{1'b1}} : st_q[DV_STG-1].q[j];
    end
  end

endmodule

/* src/parented_point_transform_unscaled_core.sv */
// Top level of the parented point transform: offsets, pipeline and output register.
`timescale 1ns / 1ps
// Usage:
// Input beats carry a local point and an optional parent basis and
// translation; each accepted beat yields exactly one output beat with the
// world point and a flag for a zero-length basis column.
// Both channels use valid and stall; a beat moves on a rising edge with
// valid high and stall low.
// The offset registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i while no beat is in flight; index 3 is ignored.
// A beat passes from input acceptance to output valid through three front
// stages (offset, multiply, sum), twenty square-root stages, one divider
// setup stage, thirty-four divider stages and the output register.
// Throughput is one beat per cycle while the receiver does not stall; every
// stage holds its own valid bit, so bubbles close up while the receiver stalls
// and a new beat is taken as long as some stage ahead of it is empty.
// Reset clears all valid bits and the offsets to zero.
module parented_point_transform_unscaled_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ppt_pkg::POS_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ppt_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ppt_pkg::out_t                     out_data_o
);
  import ppt_pkg::*;

  logic [NAX-1:0][POS_W-1:0] off_q;
  logic    fr_valid, fr_stall, sq_valid, sq_stall, dv_valid, dv_stall;
  fr_out_t fr_data;
  sq_out_t sq_data;
  dv_out_t dv_data;
  logic    out_v_q, out_rdy;
  out_t    out_d, out_q;

  // Offset registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_X: off_q[0] <= cfg_wdata_i;
        CFG_OFFSET_Y: off_q[1] <= cfg_wdata_i;
        CFG_OFFSET_Z: off_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ppt_front u_front (
    .clk_i, .rst_ni,
    .offset_i    (off_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (fr_valid),
    .out_stall_i (fr_stall),
    .out_data_o  (fr_data)
  );

  ppt_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .in_valid_i  (fr_valid),
    .in_stall_o  (fr_stall),
    .in_data_i   (fr_data),
    .out_valid_o (sq_valid),
    .out_stall_i (sq_stall),
    .out_data_o  (sq_data)
  );

  ppt_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i  (sq_valid),
    .in_stall_o  (sq_stall),
    .in_data_i   (sq_data),
    .out_valid_o (dv_valid),
    .out_stall_i (dv_stall),
    .out_data_o  (dv_data)
  );

  // Final stage: apply sign, add translation, saturate.
  always_comb begin
    logic signed [Q_W:0] qs;
    logic signed [35:0]  sm;
    logic [NAX-1:0][POS_W-1:0] w;
    for (int j = 0; j < NAX; j++) begin
      if (dv_data.side.zero[j]) begin
        qs = '0;
      end else if (dv_data.side.neg[j]) begin
        qs = -$signed({1'b0, dv_data.q[j]});
      end else begin
        qs = $signed({1'b0, dv_data.q[j]});
      end
      sm   = 36'(qs) + 36'($signed(dv_data.side.t[j]));
      w[j] = sat32(sm);
    end
    out_d.world_x         = w[0];
    out_d.world_y         = w[1];
    out_d.world_z         = w[2];
    out_d.degenerate_axis = dv_data.side.degen;
  end

  // Output register.
  assign out_rdy  = !out_v_q || !out_stall_i;
  assign dv_stall = !out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Input stalls only when the whole pipe is backed up from the output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

  // A divider beat handed over shows up in the output register.
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid && !dv_stall) |=> out_valid_o)
    else $error("divider beat lost at output register");

  // A taken output with nothing behind it empties the register.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !dv_valid) |=> !out_valid_o)
    else $error("output beat repeated");

endmodule

/* sim/tb_parented_point_transform_unscaled_core.sv */
// Self-checking testbench for the parented point transform core.
`timescale 1ns / 1ps
module tb_parented_point_transform_unscaled_core;
  import ppt_pkg::*;

  // An index past the last offset register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  // Predicts world points from input beats and compares arriving results.
  class world_point_board;
    logic [POS_W-1:0] ofs [NAX];
    out_t             pending_pts [$];
    int               errors;

    function new();
      foreach (ofs[k]) ofs[k] = '0;
      errors = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void set_offset(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
      case (idx)
        CFG_OFFSET_X: ofs[0] = val;
        CFG_OFFSET_Y: ofs[1] = val;
        CFG_OFFSET_Z: ofs[2] = val;
        default: ;
      endcase
    endfunction

    // Work out the world point of one accepted input beat.
    function void note_input(in_t x);
      longint                  pt [NAX];
      longint                  tr [NAX];
      longint                  bas [NAX][NAX];
      longint                  wp [NAX];
      logic signed [POS_W-1:0] s32;
      logic signed [POS_W-1:0] o32;
      logic signed [15:0]      e16;
      logic [3*ELEM_W-1:0]     row;
      longint unsigned         sq, len, mag, qm;
      longint                  dot, q;
      out_t                    r;
      r = '0;
      s32 = x.local_x; o32 = ofs[0]; pt[0] = clip32(longint'(s32) + longint'(o32));
      s32 = x.local_y; o32 = ofs[1]; pt[1] = clip32(longint'(s32) + longint'(o32));
      s32 = x.local_z; o32 = ofs[2]; pt[2] = clip32(longint'(s32) + longint'(o32));
      if (!x.has_parent) begin
        foreach (wp[j]) wp[j] = pt[j];
      end else begin
        for (int i = 0; i < NAX; i++) begin
          row = (i == 0) ? x.basis_row0 : (i == 1) ? x.basis_row1 : x.basis_row2;
          for (int j = 0; j < NAX; j++) begin
            e16 = row[16*j +: 16];
            bas[i][j] = e16;
          end
        end
        s32 = x.parent_tx; tr[0] = s32;
        s32 = x.parent_ty; tr[1] = s32;
        s32 = x.parent_tz; tr[2] = s32;
        for (int j = 0; j < NAX; j++) begin
          sq = 0;
          q = 0;
          for (int i = 0; i < NAX; i++) sq += longint'(bas[i][j] * bas[i][j]);
          if (sq == 0) begin
            r.degenerate_axis = 1'b1;
          end else begin
            len = root_floor(sq << 8);
            dot = 0;
            for (int i = 0; i < NAX; i++) dot += pt[i] * bas[i][j];
            mag = (dot < 0) ? longint'(-dot) : longint'(dot);
            qm = (mag * 32 + len) / (2 * len);
            q = (dot < 0) ? -longint'(qm) : longint'(qm);
          end
          wp[j] = clip32(q + tr[j]);
        end
      end
      r.world_x = wp[0][31:0];
      r.world_y = wp[1][31:0];
      r.world_z = wp[2][31:0];
      pending_pts.push_back(r);
    endfunction

    task report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    // Compare one output beat with the oldest prediction.
    task check_result(out_t got);
      out_t want;
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected beat", got.world_x, '0);
      end else begin
        want = pending_pts.pop_front();
        if (got.world_x !== want.world_x) report_mismatch("world_x", got.world_x, want.world_x);
        if (got.world_y !== want.world_y) report_mismatch("world_y", got.world_y, want.world_y);
        if (got.world_z !== want.world_z) report_mismatch("world_z", got.world_z, want.world_z);
        if (got.degenerate_axis !== want.degenerate_axis)
          report_mismatch("degenerate_axis", 32'(got.degenerate_axis),
                          32'(want.degenerate_axis));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [POS_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_t             out_data_o;

  world_point_board board;
  int               cycle_count;
  bit               no_idle;

  parented_point_transform_unscaled_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock, 2 ns period.
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall applied at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= !no_idle && ($urandom_range(99) < 34);
  end

  // Results are taken at the rising edge on which they are accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  task write_offset(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_offset(idx, val);
  endtask

  // Hold the valid beat until it is accepted, idling first at random.
  task send_beat(in_t x);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(x);
  endtask

  task wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_pts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function logic [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3, 4: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function in_t rand_beat();
    in_t x;
    bit  flat [NAX];
    x = '0;
    x.local_x = rand_pos();
    x.local_y = rand_pos();
    x.local_z = rand_pos();
    x.has_parent = ($urandom_range(99) < 80);
    foreach (flat[j]) flat[j] = ($urandom_range(99) < 8);
    for (int j = 0; j < NAX; j++) begin
      x.basis_row0[16*j +: 16] = flat[j] ? '0 : rand_elem();
      x.basis_row1[16*j +: 16] = flat[j] ? '0 : rand_elem();
      x.basis_row2[16*j +: 16] = flat[j] ? '0 : rand_elem();
    end
    x.parent_tx = rand_pos();
    x.parent_ty = rand_pos();
    x.parent_tz = rand_pos();
    return x;
  endfunction

  function in_t axis_beat(logic [POS_W-1:0] v, logic [ELEM_W-1:0] diag, logic [POS_W-1:0] t);
    in_t x;
    x = '0;
    x.local_x = v; x.local_y = v; x.local_z = v;
    x.has_parent = 1'b1;
    x.basis_row0 = {32'h0, diag};
    x.basis_row1 = {16'h0, diag, 16'h0};
    x.basis_row2 = {diag, 32'h0};
    x.parent_tx = t; x.parent_ty = t; x.parent_tz = t;
    return x;
  endfunction

  initial begin
    in_t x;
    board = new();
    cycle_count = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OFFSET_X;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats: pass-through, identity, scaled and flipped bases,
    // zero columns and saturation at both ends.
    x = '0;
    send_beat(x);
    x.local_x = 32'h7FFF_FFFF; x.local_y = 32'h8000_0000; x.local_z = 32'h0001_0000;
    x.basis_row0 = '1; x.parent_tx = '1;
    send_beat(x);
    send_beat(axis_beat(32'h0001_0000, 16'h1000, 32'h0));
    send_beat(axis_beat(32'h0003_8000, 16'h7FFF, 32'h0002_0000));
    send_beat(axis_beat(32'hFFFF_0000, 16'h8000, 32'h0));
    send_beat(axis_beat(32'h7FFF_FFFF, 16'h0001, 32'h7FFF_FFFF));
    send_beat(axis_beat(32'h8000_0000, 16'h0001, 32'h8000_0000));
    send_beat(axis_beat(32'h7FFF_FFFF, 16'h8000, 32'h7FFF_FFFF));
    send_beat(axis_beat(32'h1234_5678, 16'h0000, 32'h0ABC_DEF0));
    x = axis_beat(32'h0000_8000, 16'h1000, 32'h0);
    x.basis_row1 = '0;
    send_beat(x);
    x = '0;
    x.has_parent = 1'b1;
    x.local_x = 32'h0001_0000; x.local_y = 32'h0002_0000; x.local_z = 32'hFFFD_0000;
    x.basis_row0 = {16'h0800, 16'hF800, 16'h1000};
    x.basis_row1 = {16'h1000, 16'h0800, 16'hF000};
    x.basis_row2 = {16'hFFFF, 16'h7FFF, 16'h8000};
    x.parent_tx = 32'h8000_0000; x.parent_ty = 32'h7FFF_FFFF; x.parent_tz = 32'h5;
    send_beat(x);
    wait_drained();

    // Offsets at their extremes, plus a write to the unused index.
    write_offset(CFG_OFFSET_X, 32'h7FFF_FFFF);
    write_offset(CFG_OFFSET_Y, 32'h8000_0000);
    write_offset(CFG_OFFSET_Z, 32'h0001_0000);
    write_offset(CFG_UNUSED, 32'hDEAD_BEEF);
    send_beat(axis_beat(32'h7FFF_FFFF, 16'h1000, 32'h0));
    send_beat(axis_beat(32'h8000_0000, 16'h1000, 32'h0));
    x = '0;
    x.local_x = 32'h0000_0001; x.local_y = 32'hFFFF_FFFF;
    send_beat(x);
    for (int n = 0; n < 200; n++) send_beat(rand_beat());
    wait_drained();

    // Random phases, each with fresh offsets.
    for (int ph = 0; ph < 5; ph++) begin
      write_offset(CFG_OFFSET_X, (ph == 0) ? 32'h8000_0000 : rand_pos());
      write_offset(CFG_OFFSET_Y, (ph == 0) ? 32'h7FFF_FFFF : rand_pos());
      write_offset(CFG_OFFSET_Z, (ph == 4) ? 32'h0 : rand_pos());
      no_idle = (ph == 2);
      for (int n = 0; n < 220; n++) begin
        send_beat(rand_beat());
        // Let the pipeline empty out completely once mid-phase.
        if (ph == 1 && n == 100) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          while (board.pending_pts.size() != 0) @(negedge clk_i);
        end
      end
      no_idle = 1'b0;
      wait_drained();
    end

    if (board.errors == 0 && board.pending_pts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
